[rtl/core/wroi_pkg.sv]
// Shared constants for the weighted rectangle overlap integral block.
package wroi_pkg;

    localparam int COORD_BITS_DEF       = 16;
    localparam int WEIGHT_FRAC_BITS_DEF = 8;
    localparam int WEIGHT_INT_BITS      = 8;
    localparam int OUT_BITS             = 48;

endpackage

[rtl/core/wroi_delay.sv]
// Enabled shift line that carries a word a fixed number of stages.
module wroi_delay #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 1
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             en,
    input  logic [WIDTH-1:0] din,
    output logic [WIDTH-1:0] dout
);

    logic [WIDTH-1:0] line_reg [0:DEPTH-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < DEPTH; i++) begin
                line_reg[i] <= '0;
            end
        end else if (en) begin
            line_reg[0] <= din;
            for (int i = 1; i < DEPTH; i++) begin
                line_reg[i] <= line_reg[i-1];
            end
        end
    end

    assign dout = line_reg[DEPTH-1];

endmodule

[rtl/core/wroi_lerp.sv]
// Pipelined line interpolation w0 + d*(w1-w0)/s, truncating toward zero.
module wroi_lerp #(
    parameter int SPAN_W = 15,
    parameter int W_W    = 16
) (
    input  logic                     aclk,
    input  logic                     en,
    input  logic [SPAN_W-1:0]        d,
    input  logic [SPAN_W-1:0]        s,
    input  logic signed [W_W-1:0]    w0,
    input  logic signed [W_W-1:0]    w1,
    output logic signed [W_W-1:0]    q
);

    localparam int P_W = SPAN_W + W_W;

    logic signed [W_W:0] diff;
    logic signed [W_W:0] diff_abs;
    logic [P_W-1:0]      prod;

    assign diff     = {w1[W_W-1], w1} - {w0[W_W-1], w0};
    assign diff_abs = diff[W_W] ? -diff : diff;
    assign prod     = P_W'(d) * P_W'(diff_abs[W_W-1:0]);

    // One quotient bit per stage; the quotient never exceeds |w1-w0|.
    logic [SPAN_W-1:0]     rem_reg  [0:W_W];
    logic [W_W-1:0]        low_reg  [0:W_W];
    logic [SPAN_W-1:0]     div_reg  [0:W_W];
    logic                  neg_reg  [0:W_W];
    logic signed [W_W-1:0] base_reg [0:W_W];
    logic signed [W_W-1:0] q_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            rem_reg[0]  <= prod[P_W-1:W_W];
            low_reg[0]  <= prod[W_W-1:0];
            div_reg[0]  <= s;
            neg_reg[0]  <= diff[W_W];
            base_reg[0] <= w0;
        end
    end

    for (genvar k = 0; k < W_W; k++) begin : g_step
        logic [SPAN_W:0]   trial;
        logic [SPAN_W:0]   sub;
        logic              take;
        logic [SPAN_W-1:0] rem_next;
        logic [W_W-1:0]    low_next;

        assign trial    = {rem_reg[k], low_reg[k][W_W-1]};
        assign sub      = trial - {1'b0, div_reg[k]};
        assign take     = trial >= {1'b0, div_reg[k]};
        assign rem_next = take ? sub[SPAN_W-1:0] : trial[SPAN_W-1:0];
        assign low_next = {low_reg[k][W_W-2:0], take};

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[k+1]  <= rem_next;
                low_reg[k+1]  <= low_next;
                div_reg[k+1]  <= div_reg[k];
                neg_reg[k+1]  <= neg_reg[k];
                base_reg[k+1] <= base_reg[k];
            end
        end
    end

    logic signed [W_W:0]   step;
    logic signed [W_W:0]   sum;
    logic signed [W_W-1:0] q_next;

    assign step   = neg_reg[W_W] ? -$signed({1'b0, low_reg[W_W]})
                                 : $signed({1'b0, low_reg[W_W]});
    assign sum    = {base_reg[W_W][W_W-1], base_reg[W_W]} + step;
    assign q_next = sum[W_W-1:0];

    always_ff @(posedge aclk) begin
        if (en) begin
            q_reg <= q_next;
        end
    end

    assign q = q_reg;

endmodule

[rtl/core/weighted_rect_overlap_integral.sv]
// Throughput: one word per cycle while the pipeline advances;
// each interpolation divider retires one quotient bit a stage.
// The whole pipeline advances when the output register is empty or being taken.
// Reset (synchronous, active low) drops all words in flight and clears m_valid.
// Result is area * sum of clip-corner weights / 4, truncated toward zero.
module weighted_rect_overlap_integral #(
    parameter int COORD_BITS       = wroi_pkg::COORD_BITS_DEF,
    parameter int WEIGHT_FRAC_BITS = wroi_pkg::WEIGHT_FRAC_BITS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic signed [COORD_BITS-1:0]  s_lower_left,
    input  logic signed [COORD_BITS-1:0]  s_lower_top,
    input  logic [COORD_BITS-2:0]         s_lower_span_x,
    input  logic [COORD_BITS-2:0]         s_lower_span_y,
    input  logic signed [COORD_BITS-1:0]  s_upper_left,
    input  logic signed [COORD_BITS-1:0]  s_upper_top,
    input  logic [COORD_BITS-2:0]         s_upper_span_x,
    input  logic [COORD_BITS-2:0]         s_upper_span_y,
    input  logic signed [wroi_pkg::WEIGHT_INT_BITS+WEIGHT_FRAC_BITS-1:0] s_weight_top_left,
    input  logic signed [wroi_pkg::WEIGHT_INT_BITS+WEIGHT_FRAC_BITS-1:0] s_weight_top_right,
    input  logic signed [wroi_pkg::WEIGHT_INT_BITS+WEIGHT_FRAC_BITS-1:0] s_weight_bottom_left,
    input  logic signed [wroi_pkg::WEIGHT_INT_BITS+WEIGHT_FRAC_BITS-1:0] s_weight_bottom_right,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic signed [wroi_pkg::OUT_BITS-1:0] m_overlap_integral
);

    localparam int C   = COORD_BITS;
    localparam int SB  = COORD_BITS - 1;
    localparam int WB  = wroi_pkg::WEIGHT_INT_BITS + WEIGHT_FRAC_BITS;
    localparam int LAT = WB + 2;
    localparam int OB  = wroi_pkg::OUT_BITS;
    localparam int PW  = 2 * SB + WB + 2;
    localparam int RW  = (PW > OB) ? PW : OB;

    logic m_valid_reg;
    logic en;
    assign en      = !m_valid_reg || m_ready;
    assign s_ready = en;

    // Clip stage.
    logic signed [C:0] lx, ly, ux, uy, lxr, lyb, uxr, uyb;
    logic signed [C:0] mx, my, nx, ny, x0, x1, y0, y1;
    logic signed [C:0] dx0_w, dx1_w, dy0_w, dy1_w, ex_w, ey_w;

    assign lx  = {s_lower_left[C-1], s_lower_left};
    assign ly  = {s_lower_top[C-1], s_lower_top};
    assign ux  = {s_upper_left[C-1], s_upper_left};
    assign uy  = {s_upper_top[C-1], s_upper_top};
    assign lxr = lx + $signed({2'b00, s_lower_span_x});
    assign lyb = ly + $signed({2'b00, s_lower_span_y});
    assign uxr = ux + $signed({2'b00, s_upper_span_x});
    assign uyb = uy + $signed({2'b00, s_upper_span_y});

    assign mx = (lx > ux) ? lx : ux;
    assign my = (ly > uy) ? ly : uy;
    assign nx = (lxr < uxr) ? lxr : uxr;
    assign ny = (lyb < uyb) ? lyb : uyb;
    assign x0 = (mx < lxr) ? mx : lxr;
    assign y0 = (my < lyb) ? my : lyb;
    assign x1 = (nx > lx) ? nx : lx;
    assign y1 = (ny > ly) ? ny : ly;

    assign dx0_w = x0 - lx;
    assign dx1_w = x1 - lx;
    assign dy0_w = y0 - ly;
    assign dy1_w = y1 - ly;
    assign ex_w  = x1 - x0;
    assign ey_w  = y1 - y0;

    logic              v1_reg;
    logic [SB-1:0]     dx0_reg, dx1_reg, dy0_reg, dy1_reg, ex_reg, ey_reg, lw_reg, lh_reg;
    logic              empty_reg;
    logic signed [WB-1:0] w00_reg, w10_reg, w01_reg, w11_reg;
    logic              empty_next;

    assign empty_next = (ex_w == '0) || (ey_w == '0)
                     || (s_lower_span_x == '0) || (s_lower_span_y == '0);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            dx0_reg   <= dx0_w[SB-1:0];
            dx1_reg   <= dx1_w[SB-1:0];
            dy0_reg   <= dy0_w[SB-1:0];
            dy1_reg   <= dy1_w[SB-1:0];
            ex_reg    <= ex_w[SB-1:0];
            ey_reg    <= ey_w[SB-1:0];
            lw_reg    <= s_lower_span_x;
            lh_reg    <= s_lower_span_y;
            empty_reg <= empty_next;
            w00_reg   <= s_weight_top_left;
            w10_reg   <= s_weight_top_right;
            w01_reg   <= s_weight_bottom_left;
            w11_reg   <= s_weight_bottom_right;
        end
    end

    // Interpolate along y on the left and right edges.
    logic signed [WB-1:0] left0, right0, left1, right1;

    wroi_lerp #(.SPAN_W(SB), .W_W(WB)) u_left0 (
        .aclk(aclk), .en(en), .d(dy0_reg), .s(lh_reg),
        .w0(w00_reg), .w1(w01_reg), .q(left0));
    wroi_lerp #(.SPAN_W(SB), .W_W(WB)) u_right0 (
        .aclk(aclk), .en(en), .d(dy0_reg), .s(lh_reg),
        .w0(w10_reg), .w1(w11_reg), .q(right0));
    wroi_lerp #(.SPAN_W(SB), .W_W(WB)) u_left1 (
        .aclk(aclk), .en(en), .d(dy1_reg), .s(lh_reg),
        .w0(w00_reg), .w1(w01_reg), .q(left1));
    wroi_lerp #(.SPAN_W(SB), .W_W(WB)) u_right1 (
        .aclk(aclk), .en(en), .d(dy1_reg), .s(lh_reg),
        .w0(w10_reg), .w1(w11_reg), .q(right1));

    logic [5*SB:0] side1_in, side1_out;
    assign side1_in = {dx0_reg, dx1_reg, lw_reg, ex_reg, ey_reg, empty_reg};

    wroi_delay #(.WIDTH(5*SB+1), .DEPTH(LAT)) u_side1 (
        .aclk(aclk), .aresetn(aresetn), .en(en), .din(side1_in), .dout(side1_out));

    logic [SB-1:0] dx0_d, dx1_d, lw_d, ex_d, ey_d;
    logic          empty_d;
    assign {dx0_d, dx1_d, lw_d, ex_d, ey_d, empty_d} = side1_out;

    // Interpolate along x at the four clip corners.
    logic signed [WB-1:0] c00, c10, c01, c11;

    wroi_lerp #(.SPAN_W(SB), .W_W(WB)) u_c00 (
        .aclk(aclk), .en(en), .d(dx0_d), .s(lw_d),
        .w0(left0), .w1(right0), .q(c00));
    wroi_lerp #(.SPAN_W(SB), .W_W(WB)) u_c10 (
        .aclk(aclk), .en(en), .d(dx1_d), .s(lw_d),
        .w0(left0), .w1(right0), .q(c10));
    wroi_lerp #(.SPAN_W(SB), .W_W(WB)) u_c01 (
        .aclk(aclk), .en(en), .d(dx0_d), .s(lw_d),
        .w0(left1), .w1(right1), .q(c01));
    wroi_lerp #(.SPAN_W(SB), .W_W(WB)) u_c11 (
        .aclk(aclk), .en(en), .d(dx1_d), .s(lw_d),
        .w0(left1), .w1(right1), .q(c11));

    logic [2*SB:0] side2_in, side2_out;
    assign side2_in = {ex_d, ey_d, empty_d};

    wroi_delay #(.WIDTH(2*SB+1), .DEPTH(LAT)) u_side2 (
        .aclk(aclk), .aresetn(aresetn), .en(en), .din(side2_in), .dout(side2_out));

    logic [SB-1:0] ex_dd, ey_dd;
    logic          empty_dd;
    assign {ex_dd, ey_dd, empty_dd} = side2_out;

    logic v_corner;
    wroi_delay #(.WIDTH(1), .DEPTH(2*LAT)) u_valid (
        .aclk(aclk), .aresetn(aresetn), .en(en), .din(v1_reg), .dout(v_corner));

    // Sum and area.
    logic signed [WB+1:0] sum_next, sum_reg;
    logic [2*SB-1:0]      area_next, area_reg;
    logic                 v_sum_reg, empty_sum_reg;

    assign sum_next  = (WB+2)'(c00) + (WB+2)'(c10) + (WB+2)'(c01) + (WB+2)'(c11);
    assign area_next = (2*SB)'(ex_dd) * (2*SB)'(ey_dd);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_sum_reg <= 1'b0;
        end else if (en) begin
            v_sum_reg <= v_corner;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sum_reg       <= sum_next;
            area_reg      <= area_next;
            empty_sum_reg <= empty_dd;
        end
    end

    // Multiply by the magnitude; sign is applied after the quarter shift.
    logic [WB+1:0] mag;
    logic [PW-1:0] prod_next, prod_reg;
    logic          neg_reg, empty_mul_reg, v_mul_reg;

    assign mag       = sum_reg[WB+1] ? (WB+2)'(-sum_reg) : (WB+2)'(sum_reg);
    assign prod_next = PW'(area_reg) * PW'(mag);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_mul_reg <= 1'b0;
        end else if (en) begin
            v_mul_reg <= v_sum_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            prod_reg      <= prod_next;
            neg_reg       <= sum_reg[WB+1];
            empty_mul_reg <= empty_sum_reg;
        end
    end

    // Output register.
    logic [RW-1:0] quarter;
    logic [RW-1:0] signed_full;
    logic [OB-1:0] out_next;
    logic [OB-1:0] out_reg;

    assign quarter     = RW'(prod_reg >> 2);
    assign signed_full = neg_reg ? (~quarter + RW'(1)) : quarter;
    assign out_next    = empty_mul_reg ? '0 : signed_full[OB-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en) begin
            m_valid_reg <= v_mul_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            out_reg <= out_next;
        end
    end

    assign m_valid            = m_valid_reg;
    assign m_overlap_integral = $signed(out_reg);

endmodule

[rtl/core/wroi_checker.sv]
// Port-level checks for the overlap integral block, bound to the top level.
module wroi_checker #(
    parameter int OB = wroi_pkg::OUT_BITS
) (
    input logic          aclk,
    input logic          aresetn,
    input logic          s_ready,
    input logic          m_valid,
    input logic          m_ready,
    input logic [OB-1:0] m_overlap_integral
);

    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result word valid after reset");

    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input stalled with empty output");

    a_stall_backpressure: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |-> !s_ready)
        else $error("input taken while output stalled");

    a_hold_result: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_overlap_integral))
        else $error("stalled result word changed");

endmodule

bind weighted_rect_overlap_integral wroi_checker u_wroi_checker (
    .aclk(aclk),
    .aresetn(aresetn),
    .s_ready(s_ready),
    .m_valid(m_valid),
    .m_ready(m_ready),
    .m_overlap_integral(m_overlap_integral)
);
